// ===== hdl/sitbs_pkg.sv =====
package sitbs_pkg;

  localparam int unsigned TableDepthDefault = 1024;
  localparam int unsigned KeyW = 32;
  localparam int unsigned EntryAddrW = 64;

  typedef logic [1:0] op_t;
  localparam op_t OP_CLEAR  = 2'd0;
  localparam op_t OP_APPEND = 2'd1;
  localparam op_t OP_LOOKUP = 2'd2;

  typedef logic [1:0] status_t;
  localparam status_t ST_DONE = 2'd0;
  localparam status_t ST_MISS = 2'd1;
  localparam status_t ST_FULL = 2'd2;

  typedef struct packed {
    op_t                   operation;
    logic [KeyW-1:0]       key;
    logic [EntryAddrW-1:0] entry_address;
  } in_word_t;

  typedef struct packed {
    status_t               status;
    logic [EntryAddrW-1:0] found_address;
  } out_word_t;

  // controller to datapath
  typedef struct packed {
    logic accept;
    logic probe;
    logic check;
    logic load_out;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic start_search;
    logic hit;
    logic more;
  } stat_t;

endpackage

// ===== hdl/sitbs_ram.sv =====
module sitbs_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 1024,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/sitbs_ctrl.sv =====
module sitbs_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  input  sitbs_pkg::stat_t  stat_i,
  output sitbs_pkg::cmd_t   cmd_o
);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_READ  = 4'b0010,
    S_CHECK = 4'b0100,
    S_RESP  = 4'b1000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  always_comb begin
    cmd_o.accept   = (state_q == S_IDLE) && in_valid_i;
    cmd_o.probe    = (state_q == S_READ);
    cmd_o.check    = (state_q == S_CHECK);
    cmd_o.load_out = (state_q == S_RESP) && (!out_valid_q || out_ready_i);
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (cmd_o.accept) begin
          state_d = stat_i.start_search ? S_READ : S_RESP;
        end
      end
      S_READ: begin
        state_d = S_CHECK;
      end
      S_CHECK: begin
        state_d = (stat_i.hit || !stat_i.more) ? S_RESP : S_READ;
      end
      S_RESP: begin
        if (cmd_o.load_out) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.load_out) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

`ifndef SYNTHESIS
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.accept |=> !in_ready_o)
    else $error("input taken twice in a row");

  a_load_into_free_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load_out |-> (!out_valid_q || out_ready_i))
    else $error("output word overwritten");

  a_check_after_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CHECK) |-> ($past(state_q) == S_READ))
    else $error("compare without a memory read");
`endif

endmodule

// ===== hdl/sitbs_dp.sv =====
module sitbs_dp #(
  parameter int unsigned TABLE_DEPTH = sitbs_pkg::TableDepthDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  sitbs_pkg::in_word_t in_word_i,
  input  sitbs_pkg::cmd_t     cmd_i,
  output sitbs_pkg::stat_t    stat_o,
  output sitbs_pkg::out_word_t out_word_o
);

  localparam int unsigned CntW  = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned IdxW  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned KeyW  = sitbs_pkg::KeyW;
  localparam int unsigned EAddrW = sitbs_pkg::EntryAddrW;

  logic [CntW-1:0]   count_q;
  logic [CntW-1:0]   lo_q, hi_q;       // search window is [lo, hi)
  logic [CntW-1:0]   lo_n, hi_n;
  logic [IdxW-1:0]   mid_q;
  logic [CntW:0]     mid_sum;
  logic [IdxW-1:0]   mid_idx;
  logic [KeyW-1:0]   key_q;
  logic [KeyW-1:0]   rd_id;
  logic [EAddrW-1:0] rd_addr;
  sitbs_pkg::status_t res_status_q;
  logic [EAddrW-1:0] res_addr_q;
  sitbs_pkg::out_word_t out_q;
  logic              full;
  logic              wr_en;

  assign full  = (count_q == CntW'(TABLE_DEPTH));
  assign wr_en = cmd_i.accept && (in_word_i.operation == sitbs_pkg::OP_APPEND) && !full;

  // floor((lo + hi_incl) / 2) with hi_incl = hi - 1
  assign mid_sum = {1'b0, lo_q} + {1'b0, hi_q} - (CntW + 1)'(1);
  assign mid_idx = mid_sum[IdxW:1];

  sitbs_ram #(
    .Width (KeyW),
    .Depth (TABLE_DEPTH)
  ) u_id_ram (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (count_q[IdxW-1:0]),
    .wdata_i (in_word_i.key),
    .raddr_i (mid_idx),
    .rdata_o (rd_id)
  );

  sitbs_ram #(
    .Width (EAddrW),
    .Depth (TABLE_DEPTH)
  ) u_addr_ram (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (count_q[IdxW-1:0]),
    .wdata_i (in_word_i.entry_address),
    .raddr_i (mid_idx),
    .rdata_o (rd_addr)
  );

  always_comb begin
    lo_n = lo_q;
    hi_n = hi_q;
    if (rd_id < key_q) begin
      lo_n = CntW'(mid_q) + CntW'(1);
    end else begin
      hi_n = CntW'(mid_q);
    end
  end

  always_comb begin
    stat_o.start_search = (in_word_i.operation == sitbs_pkg::OP_LOOKUP) && (count_q != '0);
    stat_o.hit          = (rd_id == key_q);
    stat_o.more         = (lo_n < hi_n);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (cmd_i.accept) begin
      case (in_word_i.operation)
        sitbs_pkg::OP_CLEAR: begin
          count_q <= '0;
        end
        sitbs_pkg::OP_APPEND: begin
          if (!full) begin
            count_q <= count_q + CntW'(1);
          end
        end
        default: begin
          count_q <= count_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      key_q      <= in_word_i.key;
      lo_q       <= '0;
      hi_q       <= count_q;
      res_addr_q <= '0;
      case (in_word_i.operation)
        sitbs_pkg::OP_APPEND: begin
          res_status_q <= full ? sitbs_pkg::ST_FULL : sitbs_pkg::ST_DONE;
        end
        sitbs_pkg::OP_LOOKUP: begin
          res_status_q <= sitbs_pkg::ST_MISS;
        end
        default: begin
          res_status_q <= sitbs_pkg::ST_DONE;
        end
      endcase
    end
    if (cmd_i.probe) begin
      mid_q <= mid_idx;
    end
    if (cmd_i.check) begin
      if (stat_o.hit) begin
        res_status_q <= sitbs_pkg::ST_DONE;
        res_addr_q   <= rd_addr;
      end else begin
        lo_q <= lo_n;
        hi_q <= hi_n;
      end
    end
    if (cmd_i.load_out) begin
      out_q.status        <= res_status_q;
      out_q.found_address <= res_addr_q;
    end
  end

  assign out_word_o = out_q;

`ifndef SYNTHESIS
  a_count_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(TABLE_DEPTH))
    else $error("entry count beyond table depth");

  a_probe_window_open: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.probe |-> (lo_q < hi_q))
    else $error("probe with an empty search window");

  a_mid_in_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.check |-> ((CntW'(mid_q) >= lo_q) && (CntW'(mid_q) < hi_q)))
    else $error("probe index outside the search window");
`endif

endmodule

// ===== hdl/sorted_id_table_binary_search.sv =====
// sorted id table with binary-search lookup
// input channel (in_valid_i / in_ready_o / in_word_i) carries one word per item:
//   operation clear, append or lookup, a 32-bit key and a 64-bit entry address
// output channel (out_valid_o / out_ready_i / out_word_o) returns exactly one
//   word per item: status (done/found, not found, table full) and found address
// appends fill the table in order; ids are expected in ascending order
// one item is worked on at a time; in_ready_o is high whenever the engine is idle,
//   even while an earlier result still sits in the output register
// clear, append and ignored codes: accept, then the output register is loaded
// lookup: accept, then per probe a memory read state and a compare state, at most
//   ceil(log2(TABLE_DEPTH+1)) probes, then the response state; each probe is a
//   registered memory read and then a compare, set by the single read port of the table
// a receiver stall holds the output word; a finished result then waits in the
//   response state and the next item is taken only once it has moved out
// reset empties the table (entry count to zero) and drops any pending word;
//   the table memory itself is not cleared and needs no clearing pass
module sorted_id_table_binary_search #(
  parameter int unsigned TABLE_DEPTH = sitbs_pkg::TableDepthDefault
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  sitbs_pkg::in_word_t  in_word_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output sitbs_pkg::out_word_t out_word_o
);

  // command and status between sequencer and datapath
  sitbs_pkg::cmd_t  cmd;
  sitbs_pkg::stat_t stat;

  // sequencer: idle, memory read, compare, response hand-off
  sitbs_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  // datapath: entry count, search bounds, table memories and output word
  sitbs_dp #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_word_i  (in_word_i),
    .cmd_i      (cmd),
    .stat_o     (stat),
    .out_word_o (out_word_o)
  );

endmodule

// ===== test/testbench.sv =====
module testbench;

  localparam int unsigned TableDepth = 1024;
  // the one code of the 2-bit operation field that the block ignores
  localparam sitbs_pkg::op_t OpUnused = 2'd3;
  // items to send after the directed ones, full-table fill included
  localparam int unsigned RandomItems = 1200;
  // random items before the full-table fill starts
  localparam int unsigned FillStart = 100;
  // long receiver hold-off, in cycles, that backs the block up
  localparam int unsigned LongHold = 400;
  // cycles with no word moving on either side before the run is called hung
  localparam int unsigned QuietLimit = 4000;
  // drain time after the last expected word, well above the longest lookup
  localparam int unsigned TailCycles = 60;

  // expected-reply tracker: its own copy of the id table plus the words still owed
  class table_reply_checker;
    logic [sitbs_pkg::KeyW-1:0]       ids   [TableDepth];
    logic [sitbs_pkg::EntryAddrW-1:0] addrs [TableDepth];
    int unsigned                      count;
    sitbs_pkg::out_word_t             pending_replies [$];
    int unsigned                      errors;

    function new();
      count  = 0;
      errors = 0;
    endfunction

    // apply one item to the table copy and return the reply it should produce
    function sitbs_pkg::out_word_t predict(sitbs_pkg::in_word_t w);
      sitbs_pkg::out_word_t r;
      int        lo;
      int        hi;
      int        mid;
      r = '0;
      r.status = sitbs_pkg::ST_DONE;
      case (w.operation)
        sitbs_pkg::OP_CLEAR: begin
          count = 0;
        end
        sitbs_pkg::OP_APPEND: begin
          if (count >= TableDepth) begin
            r.status = sitbs_pkg::ST_FULL;
          end else begin
            ids[count]   = w.key;
            addrs[count] = w.entry_address;
            count++;
          end
        end
        sitbs_pkg::OP_LOOKUP: begin
          // probe floor((lo+hi)/2) until hit or the bounds cross
          r.status = sitbs_pkg::ST_MISS;
          lo = 0;
          hi = int'(count) - 1;
          while (lo <= hi && r.status == sitbs_pkg::ST_MISS) begin
            mid = (lo + hi) / 2;
            if (ids[mid] == w.key) begin
              r.status = sitbs_pkg::ST_DONE;
              r.found_address = addrs[mid];
            end else if (ids[mid] < w.key) begin
              lo = mid + 1;
            end else begin
              hi = mid - 1;
            end
          end
        end
        default: begin
        end
      endcase
      return r;
    endfunction

    function void note_item(sitbs_pkg::in_word_t w);
      pending_replies.insert(pending_replies.size(), predict(w));
    endfunction

    function void check_reply(sitbs_pkg::out_word_t got);
      sitbs_pkg::out_word_t exp;
      if (pending_replies.size() == 0) begin
        $display("%0t: reply with nothing pending: status %0d address %h",
                 $time, got.status, got.found_address);
        errors++;
        return;
      end
      exp = pending_replies.pop_front();
      if (got.status !== exp.status) begin
        $display("%0t: status mismatch: expected %0d, actual %0d",
                 $time, exp.status, got.status);
        errors++;
      end
      if (got.found_address !== exp.found_address) begin
        $display("%0t: found_address mismatch: expected %h, actual %h",
                 $time, exp.found_address, got.found_address);
        errors++;
      end
    endfunction
  endclass

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 in_valid_i = 1'b0;
  logic                 in_ready_o;
  sitbs_pkg::in_word_t  in_word_i = '0;
  logic                 out_valid_o;
  logic                 out_ready_i = 1'b0;
  sitbs_pkg::out_word_t out_word_o;

  table_reply_checker reply_check = new();

  // idle mix of the current phase, in percent of cycles
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  // raised by the stimulus, taken down by the receiver when it starts the hold-off
  bit          long_hold_pending = 1'b0;
  // items that do something (clear, append, lookup) sent so far
  int unsigned items_sent = 0;
  int unsigned quiet_cycles = 0;
  // ids of the last table loaded, for picking lookup keys
  logic [sitbs_pkg::KeyW-1:0] loaded_keys [$];

  sorted_id_table_binary_search #(
    .TABLE_DEPTH(TableDepth)
  ) uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_word_i  (in_word_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_word_o (out_word_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // output side: check every word taken at an edge
  // (block outputs still hold their pre-edge values in the active region)
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      reply_check.check_reply(out_word_o);
    end
  end

  // receiver: random stalls, plus one long hold-off on request
  initial begin
    forever begin
      @(posedge clk_i);
      if (long_hold_pending) begin
        long_hold_pending = 1'b0;
        out_ready_i <= 1'b0;
        repeat (LongHold) @(posedge clk_i);
      end else begin
        out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // hang detector: cycles in which no word moves on either channel
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == QuietLimit) begin
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  function automatic logic [sitbs_pkg::EntryAddrW-1:0] random_address();
    return {$urandom(), $urandom()};
  endfunction

  // rotate the idle mix: none, sender idle, receiver stalling, both
  task automatic pick_idle_phase();
    case ((items_sent / 150) % 4)
      0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      1: begin send_idle_pct = 69; recv_stall_pct = 0;  end
      2: begin send_idle_pct = 0;  recv_stall_pct = 69; end
      default: begin send_idle_pct = 17; recv_stall_pct = 17; end
    endcase
  endtask

  // offer one word, with an optional idle gap first, and wait until it is taken;
  // valid is left high so a back-to-back word needs no second assignment
  task automatic send_item(input sitbs_pkg::op_t op, input logic [sitbs_pkg::KeyW-1:0] key,
                           input logic [sitbs_pkg::EntryAddrW-1:0] addr);
    sitbs_pkg::in_word_t w;
    w.operation     = op;
    w.key           = key;
    w.entry_address = addr;
    pick_idle_phase();
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_word_i  <= w;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    reply_check.note_item(w);
    if (op != OpUnused) items_sent++;
  endtask

  // append n random ids in ascending order
  task automatic load_sorted_table(input int unsigned n);
    loaded_keys.delete();
    repeat (n) loaded_keys.insert(loaded_keys.size(), $urandom());
    loaded_keys.sort();
    foreach (loaded_keys[i]) send_item(sitbs_pkg::OP_APPEND, loaded_keys[i], random_address());
  endtask

  // lookups: mostly loaded ids, some near misses, some random keys
  task automatic lookup_some(input int unsigned m);
    logic [sitbs_pkg::KeyW-1:0] k;
    repeat (m) begin
      if (loaded_keys.size() != 0 && $urandom_range(99) < 70) begin
        k = loaded_keys[$urandom_range(loaded_keys.size() - 1)];
        if ($urandom_range(9) == 0) k = k + 1;
      end else begin
        k = $urandom();
      end
      send_item(sitbs_pkg::OP_LOOKUP, k, random_address());
    end
  endtask

  initial begin
    int unsigned rand_start;
    int unsigned pick;
    int unsigned n;
    bit          fill_done;

    fill_done  = 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: empty table, field extremes, ignored code
    send_item(sitbs_pkg::OP_LOOKUP, '0, random_address());
    send_item(sitbs_pkg::OP_LOOKUP, '1, random_address());
    send_item(OpUnused, '1, '1);
    send_item(sitbs_pkg::OP_APPEND, '0, '0);
    send_item(sitbs_pkg::OP_APPEND, 32'h0000_0005, '1);
    send_item(sitbs_pkg::OP_APPEND, 32'h7fff_ffff, 64'h8000_0000_0000_0001);
    send_item(sitbs_pkg::OP_APPEND, '1, random_address());
    send_item(sitbs_pkg::OP_LOOKUP, '0, '0);
    send_item(sitbs_pkg::OP_LOOKUP, '1, '1);
    send_item(sitbs_pkg::OP_LOOKUP, 32'h0000_0005, '0);
    send_item(sitbs_pkg::OP_LOOKUP, 32'h0000_0006, '0);
    send_item(sitbs_pkg::OP_LOOKUP, 32'h8000_0000, '0);
    // ignored code must leave the table alone
    send_item(OpUnused, 32'h0000_0005, '0);
    send_item(sitbs_pkg::OP_LOOKUP, 32'h0000_0005, '0);
    // duplicate ids: whichever copy the probe order hits first
    send_item(sitbs_pkg::OP_CLEAR, '0, '0);
    send_item(sitbs_pkg::OP_APPEND, 32'd3, 64'h1111);
    send_item(sitbs_pkg::OP_APPEND, 32'd3, 64'h2222);
    send_item(sitbs_pkg::OP_APPEND, 32'd3, 64'h3333);
    send_item(sitbs_pkg::OP_LOOKUP, 32'd3, '0);
    // descending table: the search may miss an id that is there
    send_item(sitbs_pkg::OP_CLEAR, '1, '1);
    send_item(sitbs_pkg::OP_APPEND, 32'd9, 64'h9);
    send_item(sitbs_pkg::OP_APPEND, 32'd5, 64'h5);
    send_item(sitbs_pkg::OP_APPEND, 32'd1, 64'h1);
    send_item(sitbs_pkg::OP_LOOKUP, 32'd1, '0);
    send_item(sitbs_pkg::OP_LOOKUP, 32'd9, '0);
    // clear then lookup: empty again
    send_item(sitbs_pkg::OP_CLEAR, '0, '0);
    send_item(sitbs_pkg::OP_LOOKUP, 32'd5, '0);

    rand_start = items_sent;
    while (items_sent - rand_start < RandomItems) begin
      if (!fill_done && items_sent - rand_start >= FillStart) begin
        // full table: the long hold-off starts while the appends pour in
        fill_done = 1'b1;
        long_hold_pending = 1'b1;
        send_item(sitbs_pkg::OP_CLEAR, '0, '0);
        load_sorted_table(TableDepth);
        repeat (3) send_item(sitbs_pkg::OP_APPEND, $urandom(), random_address());
        send_item(sitbs_pkg::OP_LOOKUP, loaded_keys[0], '0);
        send_item(sitbs_pkg::OP_LOOKUP, loaded_keys[TableDepth-1], '0);
        send_item(sitbs_pkg::OP_LOOKUP, '0, '0);
        send_item(sitbs_pkg::OP_LOOKUP, '1, '0);
        lookup_some(30);
        send_item(sitbs_pkg::OP_CLEAR, '0, '0);
        continue;
      end
      pick = $urandom_range(99);
      if (pick < 75) begin
        // well-formed: clear, ascending load, lookups
        if ($urandom_range(9) != 0) begin
          send_item(sitbs_pkg::OP_CLEAR, $urandom(), random_address());
        end
        if ($urandom_range(9) == 0) n = $urandom_range(25, 200);
        else n = $urandom_range(0, 24);
        load_sorted_table(n);
        lookup_some($urandom_range(1, 2 * n + 2));
      end else if (pick < 90) begin
        // broken: unsorted ids from a narrow range, so duplicates too
        send_item(sitbs_pkg::OP_CLEAR, $urandom(), random_address());
        loaded_keys.delete();
        repeat ($urandom_range(1, 16)) begin
          loaded_keys.insert(loaded_keys.size(), $urandom_range(0, 15));
          send_item(sitbs_pkg::OP_APPEND, loaded_keys[$], random_address());
        end
        lookup_some($urandom_range(1, 12));
      end else begin
        // noise: any code, any fields
        repeat ($urandom_range(1, 10)) begin
          send_item(sitbs_pkg::op_t'($urandom_range(0, 3)), $urandom(), random_address());
        end
      end
    end
    in_valid_i <= 1'b0;

    // drain, then give a stray word time to show up
    while (reply_check.pending_replies.size() != 0) @(posedge clk_i);
    repeat (TailCycles) @(posedge clk_i);
    if (reply_check.errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
